@@ src/dsv_pkg.sv @@
// ----------------------------------------------------------------------------
// dsv_pkg
// shared types and constants of the date string validator
// ----------------------------------------------------------------------------
`default_nettype none

package dsv_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned LenWidth   = 3;
   localparam int unsigned SmallWidth = 7;
   localparam int unsigned YearWidth  = 14;

   // character codes
   localparam logic [CharWidth-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CharWidth-1:0] CHAR_SLASH = 8'd47;
   localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CharWidth-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CharWidth-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CharWidth-1:0] CHAR_CR    = 8'd13;

   // field length limits
   localparam logic [LenWidth-1:0] LEN_MAX       = 3'd7;
   localparam logic [LenWidth-1:0] LEN_SMALL_MAX = 3'd2;
   localparam logic [LenWidth-1:0] LEN_YEAR_MAX  = 3'd4;

   // year limits
   localparam logic [YearWidth-1:0] YEAR_SHORT_LIMIT = 14'd100;
   localparam logic [YearWidth-1:0] YEAR_BASE        = 14'd2000;
   localparam logic [YearWidth-1:0] YEAR_MIN         = 14'd1900;
   localparam logic [YearWidth-1:0] YEAR_MAX         = 14'd2101;
   localparam logic [YearWidth-1:0] YEAR_NOLEAP_A    = 14'd1900;
   localparam logic [YearWidth-1:0] YEAR_NOLEAP_B    = 14'd2100;

   typedef enum logic [1:0] {
      FLD_DAY,
      FLD_MONTH,
      FLD_YEAR
   } field_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_NUM,
      PH_DONE
   } phase_type;

   // parse state seen by the date check
   typedef struct packed {
      field_type               field;
      logic [LenWidth-1:0]     len;
      logic                    neg;
      logic                    ferr;
      logic [SmallWidth-1:0]   day;
      logic [SmallWidth-1:0]   month;
      logic [YearWidth-1:0]    year;
   } fields_type;

endpackage

`default_nettype wire

@@ src/dsv_parser.sv @@
// ----------------------------------------------------------------------------
// dsv_parser
// per-character parse state update for day, month and year fields
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic [dsv_pkg::CharWidth-1:0]  char_val,
   output dsv_pkg::fields_type                 fields
);

   dsv_pkg::field_type                  field_ff, field_in;
   dsv_pkg::phase_type                  phase_ff, phase_in;
   logic [dsv_pkg::LenWidth-1:0]        len_ff, len_in;
   logic                                neg_ff, neg_in;
   logic                                ferr_ff, ferr_in;
   logic [dsv_pkg::SmallWidth-1:0]      day_ff, day_in;
   logic [dsv_pkg::SmallWidth-1:0]      month_ff, month_in;
   logic [dsv_pkg::YearWidth-1:0]       cur_ff, cur_in;

   logic                                is_digit;
   logic                                is_space;
   logic [dsv_pkg::YearWidth-1:0]       digit_val;
   logic [dsv_pkg::LenWidth-1:0]        max_len;
   logic [dsv_pkg::SmallWidth-1:0]      small_val;

   assign is_digit  = (char_val >= dsv_pkg::CHAR_ZERO) && (char_val <= dsv_pkg::CHAR_NINE);
   assign is_space  = (char_val == dsv_pkg::CHAR_SPACE) ||
                      ((char_val >= dsv_pkg::CHAR_TAB) && (char_val <= dsv_pkg::CHAR_CR));
   assign digit_val = {{(dsv_pkg::YearWidth-4){1'b0}}, char_val[3:0]};
   assign max_len   = (field_ff == dsv_pkg::FLD_YEAR) ? dsv_pkg::LEN_YEAR_MAX
                                                      : dsv_pkg::LEN_SMALL_MAX;
   assign small_val = neg_ff ? '0 : cur_ff[dsv_pkg::SmallWidth-1:0];

   always_comb begin
      field_in = field_ff;
      phase_in = phase_ff;
      len_in   = len_ff;
      neg_in   = neg_ff;
      ferr_in  = ferr_ff;
      day_in   = day_ff;
      month_in = month_ff;
      cur_in   = cur_ff;
      if (step) begin
         if (char_val == dsv_pkg::CHAR_NUL) begin
            // end of string, rearm
            field_in = dsv_pkg::FLD_DAY;
            phase_in = dsv_pkg::PH_SKIP;
            len_in   = '0;
            neg_in   = 1'b0;
            ferr_in  = 1'b0;
            day_in   = '0;
            month_in = '0;
            cur_in   = '0;
         end else if ((char_val == dsv_pkg::CHAR_SLASH) &&
                      (field_ff != dsv_pkg::FLD_YEAR)) begin
            // close day or month field
            if ((len_ff != 3'd1) && (len_ff != 3'd2)) begin
               ferr_in = 1'b1;
            end
            case (field_ff)
               dsv_pkg::FLD_DAY: begin
                  day_in   = small_val;
                  field_in = dsv_pkg::FLD_MONTH;
               end
               default: begin
                  month_in = small_val;
                  field_in = dsv_pkg::FLD_YEAR;
               end
            endcase
            phase_in = dsv_pkg::PH_SKIP;
            len_in   = '0;
            neg_in   = 1'b0;
            cur_in   = '0;
         end else begin
            if (len_ff < max_len) begin
               case (phase_ff)
                  dsv_pkg::PH_SKIP: begin
                     if (is_space) begin
                        phase_in = dsv_pkg::PH_SKIP;
                     end else if ((char_val == dsv_pkg::CHAR_PLUS) ||
                                  (char_val == dsv_pkg::CHAR_MINUS)) begin
                        neg_in   = (char_val == dsv_pkg::CHAR_MINUS);
                        phase_in = dsv_pkg::PH_NUM;
                     end else if (is_digit) begin
                        cur_in   = digit_val;
                        phase_in = dsv_pkg::PH_NUM;
                     end else begin
                        phase_in = dsv_pkg::PH_DONE;
                     end
                  end
                  dsv_pkg::PH_NUM: begin
                     if (is_digit) begin
                        cur_in = (cur_ff << 3) + (cur_ff << 1) + digit_val;
                     end else begin
                        phase_in = dsv_pkg::PH_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            if (len_ff != dsv_pkg::LEN_MAX) begin
               len_in = len_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= dsv_pkg::FLD_DAY;
         phase_ff <= dsv_pkg::PH_SKIP;
         len_ff   <= '0;
         neg_ff   <= 1'b0;
         ferr_ff  <= 1'b0;
         day_ff   <= '0;
         month_ff <= '0;
         cur_ff   <= '0;
      end else begin
         field_ff <= field_in;
         phase_ff <= phase_in;
         len_ff   <= len_in;
         neg_ff   <= neg_in;
         ferr_ff  <= ferr_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         cur_ff   <= cur_in;
      end
   end

   // the year value equals the running value while in the year field
   assign fields.field = field_ff;
   assign fields.len   = len_ff;
   assign fields.neg   = neg_ff;
   assign fields.ferr  = ferr_ff;
   assign fields.day   = day_ff;
   assign fields.month = month_ff;
   assign fields.year  = cur_ff;

endmodule

`default_nettype wire

@@ src/dsv_check.sv @@
// ----------------------------------------------------------------------------
// dsv_check
// calendar check of the parsed day, month and year
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_check (
   input  wire dsv_pkg::fields_type  fields,
   output logic                      date_ok
);

   logic [dsv_pkg::YearWidth-1:0]  year_adj;
   logic                           leap;
   logic [4:0]                     day_lim;

   always_comb begin
      year_adj = fields.year;
      if (fields.year < dsv_pkg::YEAR_SHORT_LIMIT) begin
         year_adj = fields.year + dsv_pkg::YEAR_BASE;
      end
      // only years in 1900..2101 reach here when it matters
      leap = (year_adj[1:0] == 2'd0) && (year_adj != dsv_pkg::YEAR_NOLEAP_A) &&
             (year_adj != dsv_pkg::YEAR_NOLEAP_B);
      case (fields.month)
         7'd2:                         day_lim = leap ? 5'd29 : 5'd28;
         7'd4, 7'd6, 7'd9, 7'd11:      day_lim = 5'd30;
         default:                      day_lim = 5'd31;
      endcase

      date_ok = 1'b1;
      if (fields.ferr || (fields.field != dsv_pkg::FLD_YEAR)) begin
         date_ok = 1'b0;
      end
      if ((fields.len != dsv_pkg::LEN_SMALL_MAX) && (fields.len != dsv_pkg::LEN_YEAR_MAX)) begin
         date_ok = 1'b0;
      end
      if (fields.neg && (fields.year != '0)) begin
         date_ok = 1'b0;
      end
      if ((year_adj < dsv_pkg::YEAR_MIN) || (year_adj > dsv_pkg::YEAR_MAX)) begin
         date_ok = 1'b0;
      end
      if ((fields.month < 7'd1) || (fields.month > 7'd12)) begin
         date_ok = 1'b0;
      end
      if ((fields.day < 7'd1) || (fields.day > {2'b00, day_lim})) begin
         date_ok = 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ src/date_string_validator_core.sv @@
// ----------------------------------------------------------------------------
// date_string_validator_core
// checks a d/m/y date string fed one character per item
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  req       req_valid, req_stall, req_character     in  (one character)
//  rsp       rsp_valid, rsp_stall, rsp_date_valid    out (one per NUL)
//
//  one character per cycle unless req_stall; the NUL verdict is registered
//  characters pass an input register, then the registered parse update
//  the output register holds a result under stall; other characters keep flowing
//  only a NUL waiting on a full output register stalls the input side
//  synchronous active-high reset returns the parser to the day field
// ----------------------------------------------------------------------------
`default_nettype none

module date_string_validator_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [dsv_pkg::CharWidth-1:0]  req_character,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_date_valid
);

   // input register
   logic                              in_valid_ff, in_valid_in;
   logic [dsv_pkg::CharWidth-1:0]     char_ff, char_in;

   // result register
   logic                              out_valid_ff, out_valid_in;
   logic                              out_date_ff, out_date_in;

   logic                              is_nul;
   logic                              out_free;
   logic                              step;
   logic                              date_ok;
   dsv_pkg::fields_type               fields;

   assign is_nul    = (char_ff == dsv_pkg::CHAR_NUL);
   assign out_free  = !out_valid_ff || !rsp_stall;
   // non-NUL characters never need the result register
   assign step      = in_valid_ff && (!is_nul || out_free);
   assign req_stall = in_valid_ff && !step;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         char_in     = req_character;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_date_in  = out_date_ff;
      if (step && is_nul) begin
         out_valid_in = 1'b1;
         out_date_in  = date_ok;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      char_ff     <= char_in;
      out_date_ff <= out_date_in;
   end

   dsv_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_val (char_ff),
      .fields   (fields)
   );

   // check reads the state before the NUL clears it
   dsv_check u_check (
      .fields  (fields),
      .date_ok (date_ok)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_date_valid = out_date_ff;

`ifndef ASSERT_OFF
   // input side only stalls on a NUL blocked by a held result
   a_stall_only_nul: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_nul && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked NUL");

   // a NUL rearms the parser
   a_nul_rearms: assert property (@(posedge clock) disable iff (reset)
      (step && is_nul) |=> (fields.field == dsv_pkg::FLD_DAY) && (fields.len == '0)
                           && !fields.ferr)
      else $error("parser not rearmed after NUL");

   // first slash moves to the month field
   a_slash_month: assert property (@(posedge clock) disable iff (reset)
      (step && (char_ff == dsv_pkg::CHAR_SLASH) && (fields.field == dsv_pkg::FLD_DAY))
      |=> (fields.field == dsv_pkg::FLD_MONTH))
      else $error("slash did not close day field");
`endif

endmodule

`default_nettype wire

@@ dv/tb_date_string_validator_core.sv @@
// ----------------------------------------------------------------------------
// tb_date_string_validator_core
// self-checking bench for the d/m/y date string validator
// ----------------------------------------------------------------------------
//  feeds date strings one character per item and keeps its own parser model
//  of the day, month and year fields. Every NUL queues the date verdict that
//  the model predicts, and each verdict from the block is checked against the
//  oldest queued one. A directed set of calendar corner cases runs first.
//  Random strings follow: mostly well-formed dates near the limits, some with
//  a single corruption, and some pure byte noise. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_date_string_validator_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [dsv_pkg::CharWidth-1:0] char_type;
   typedef char_type char_queue_type[$];

   localparam int unsigned MONTH_FEB  = 2;
   localparam int unsigned MONTH_APR  = 4;
   localparam int unsigned MONTH_JUN  = 6;
   localparam int unsigned MONTH_SEP  = 9;
   localparam int unsigned MONTH_NOV  = 11;
   localparam int unsigned MONTH_LAST = 12;
   localparam int unsigned REPORT_MAX = 10;

   // ---------------------------------------------------------------------------
   // date parser model plus the queue of verdicts still owed by the block
   // ---------------------------------------------------------------------------
   class date_scoreboard;
      dsv_pkg::field_type                  fld;
      logic [dsv_pkg::LenWidth-1:0]        flen;
      dsv_pkg::phase_type                  phase;
      logic                                neg;
      logic                                ferr;
      logic [dsv_pkg::SmallWidth-1:0]      day;
      logic [dsv_pkg::SmallWidth-1:0]      month;
      logic [dsv_pkg::YearWidth-1:0]       year;
      logic [dsv_pkg::YearWidth-1:0]       acc;
      bit                                  verdicts_due[$];
      int                                  errors;
      int                                  checked;
      int                                  valid_seen;

      function new();
         errors     = 0;
         checked    = 0;
         valid_seen = 0;
         clear();
      endfunction

      function void clear();
         fld   = dsv_pkg::FLD_DAY;
         flen  = '0;
         phase = dsv_pkg::PH_SKIP;
         neg   = 1'b0;
         ferr  = 1'b0;
         day   = '0;
         month = '0;
         year  = '0;
         acc   = '0;
      endfunction

      function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      // verdict for the string seen so far
      function bit date_ok();
         int unsigned y;
         int unsigned m;
         int unsigned d;
         int unsigned lim;
         y = year;
         m = month;
         d = day;
         if (ferr || fld != dsv_pkg::FLD_YEAR) return 1'b0;
         if (flen != 3'd2 && flen != dsv_pkg::LEN_YEAR_MAX) return 1'b0;
         if (neg && y != 0) return 1'b0;
         if (y < dsv_pkg::YEAR_SHORT_LIMIT) y += dsv_pkg::YEAR_BASE;
         else if (y < dsv_pkg::YEAR_MIN || y > dsv_pkg::YEAR_MAX) return 1'b0;
         if (m < 1 || m > MONTH_LAST) return 1'b0;
         if (m == MONTH_FEB) lim = leap_year(y) ? 29 : 28;
         else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            lim = 30;
         else lim = 31;
         return (d >= 1 && d <= lim);
      endfunction

      // one accepted character
      function void note_char(char_type c);
         int unsigned maxlen;
         logic [dsv_pkg::SmallWidth-1:0] v;
         bit digit;
         bit space;
         maxlen = (fld == dsv_pkg::FLD_YEAR) ? dsv_pkg::LEN_YEAR_MAX : dsv_pkg::LEN_SMALL_MAX;
         if (c == dsv_pkg::CHAR_NUL) begin
            verdicts_due.push_back(date_ok());
            clear();
            return;
         end
         if (c == dsv_pkg::CHAR_SLASH && fld != dsv_pkg::FLD_YEAR) begin
            v = neg ? '0 : acc[dsv_pkg::SmallWidth-1:0];
            if (flen != 3'd1 && flen != 3'd2) ferr = 1'b1;
            if (fld == dsv_pkg::FLD_DAY) begin
               day = v;
               fld = dsv_pkg::FLD_MONTH;
            end else begin
               month = v;
               fld   = dsv_pkg::FLD_YEAR;
            end
            flen  = '0;
            phase = dsv_pkg::PH_SKIP;
            neg   = 1'b0;
            acc   = '0;
            return;
         end
         if (flen < maxlen) begin
            digit = (c >= dsv_pkg::CHAR_ZERO && c <= dsv_pkg::CHAR_NINE);
            space = (c == dsv_pkg::CHAR_SPACE ||
                     (c >= dsv_pkg::CHAR_TAB && c <= dsv_pkg::CHAR_CR));
            case (phase)
               dsv_pkg::PH_SKIP: begin
                  if (space) begin
                  end else if (c == dsv_pkg::CHAR_PLUS || c == dsv_pkg::CHAR_MINUS) begin
                     neg   = (c == dsv_pkg::CHAR_MINUS);
                     phase = dsv_pkg::PH_NUM;
                  end else if (digit) begin
                     acc   = dsv_pkg::YearWidth'(int'(c) - int'(dsv_pkg::CHAR_ZERO));
                     phase = dsv_pkg::PH_NUM;
                  end else begin
                     phase = dsv_pkg::PH_DONE;
                  end
               end
               dsv_pkg::PH_NUM: begin
                  if (digit)
                     acc = dsv_pkg::YearWidth'(int'(acc) * 10 + int'(c)
                                               - int'(dsv_pkg::CHAR_ZERO));
                  else phase = dsv_pkg::PH_DONE;
               end
               default: begin
               end
            endcase
            if (fld == dsv_pkg::FLD_YEAR) year = acc;
         end
         if (flen < dsv_pkg::LEN_MAX) flen++;
      endfunction

      function void flag(string what, int want, int got);
         errors++;
         if (errors <= REPORT_MAX)
            $display("[%0t] mismatch: %s expected %0d actual %0d", $realtime, what, want, got);
      endfunction

      // one accepted verdict from the block
      function void check_verdict(logic got);
         bit want;
         if (verdicts_due.size() == 0) begin
            flag("verdict with none due", -1, got);
            return;
         end
         want = verdicts_due.pop_front();
         checked++;
         if (want) valid_seen++;
         if (got !== want) flag("date_valid", want, got);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, reset, block
   // ---------------------------------------------------------------------------
   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   char_type req_character = '0;
   logic     rsp_stall     = 1'b0;
   logic     req_stall;
   logic     rsp_valid;
   logic     rsp_date_valid;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   date_string_validator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_date_valid (rsp_date_valid)
   );

   date_scoreboard sb = new();

   // idle odds in percent, changed per phase of the run
   int tx_idle = 35;
   int rx_idle = 52;
   int chars_sent   = 0;
   int strings_sent = 0;

   // receiver stalls at random; one assignment per edge
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle);
   end

   // both channels watched at the edge, before any nonblocking update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_char(req_character);
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_date_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------

   // one character: random idle cycles, then hold until accepted
   task automatic send_char(input char_type c);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   // whole string, closed by the NUL
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(char_type'(s[i]));
      send_char(dsv_pkg::CHAR_NUL);
      strings_sent++;
   endtask

   task automatic send_queue(input char_queue_type s);
      foreach (s[i]) send_char(s[i]);
      send_char(dsv_pkg::CHAR_NUL);
      strings_sent++;
   endtask

   // zero-padded decimal of a fixed digit count
   function automatic void put_digits(ref char_queue_type s, input int unsigned v,
                                      input int unsigned ndig);
      int unsigned p;
      p = 1;
      repeat (ndig - 1) p *= 10;
      repeat (ndig) begin
         s.push_back(char_type'(int'(dsv_pkg::CHAR_ZERO) + (v / p) % 10));
         p /= 10;
      end
   endfunction

   // day or month field, now and then with a leading blank or a sign
   function automatic void put_small(ref char_queue_type s, input int unsigned v);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) begin
         s.push_back(dsv_pkg::CHAR_SPACE);
         put_digits(s, v % 10, 1);
      end else if (r < 12) begin
         s.push_back(dsv_pkg::CHAR_PLUS);
         put_digits(s, v % 10, 1);
      end else if (r < 15) begin
         s.push_back(dsv_pkg::CHAR_MINUS);
         put_digits(s, v % 10, 1);
      end else if (v < 10 && r < 55) begin
         put_digits(s, v, 1);
      end else begin
         put_digits(s, v, 2);
      end
   endfunction

   function automatic void put_year(ref char_queue_type s);
      int unsigned picks[12] = '{1899, 1900, 1904, 1996, 2000, 2004,
                                 2024, 2096, 2100, 2101, 2102, 9999};
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) begin
         put_digits(s, $urandom_range(0, 99), 2);
      end else if (r < 40) begin
         put_digits(s, $urandom_range(0, 99), 4);
      end else if (r < 70) begin
         put_digits(s, picks[$urandom_range(0, 11)], 4);
      end else if (r < 95) begin
         put_digits(s, $urandom_range(1890, 2110), 4);
      end else begin
         s.push_back(dsv_pkg::CHAR_MINUS);
         put_digits(s, $urandom_range(0, 9), $urandom_range(1, 3));
      end
   endfunction

   // mostly well-formed dates near the limits, some corrupted, some noise
   task automatic send_random_string();
      int unsigned edges[7] = '{0, 1, 28, 29, 30, 31, 32};
      char_queue_type s;
      int unsigned kind;
      int unsigned d;
      int unsigned m;
      int unsigned i;
      int unsigned n;
      kind = $urandom_range(99);
      if (kind < 85) begin
         d = ($urandom_range(99) < 40) ? edges[$urandom_range(0, 6)] : $urandom_range(1, 31);
         n = $urandom_range(99);
         if (n < 10) m = ($urandom_range(1) != 0) ? 13 : 0;
         else if (n < 35) m = MONTH_FEB;
         else m = $urandom_range(1, MONTH_LAST);
         put_small(s, d);
         s.push_back(dsv_pkg::CHAR_SLASH);
         put_small(s, m);
         s.push_back(dsv_pkg::CHAR_SLASH);
         put_year(s);
         // broken sequences: one corruption at a random spot
         if (kind >= 70) begin
            i = $urandom_range(0, s.size() - 1);
            case ($urandom_range(3))
               0: s[i] = char_type'($urandom_range(1, 255));
               1: s.insert(i, ($urandom_range(1) != 0) ? char_type'($urandom_range(1, 255))
                                                        : char_type'($urandom_range(48, 57)));
               2: s.delete(i);
               default: repeat (s.size() - i) s.delete(s.size() - 1);
            endcase
         end
      end else begin
         // raw bytes, slashes now and then; an inner NUL just ends early
         n = $urandom_range(0, 10);
         repeat (n) begin
            if ($urandom_range(99) < 20) s.push_back(dsv_pkg::CHAR_SLASH);
            else s.push_back(char_type'($urandom_range(0, 255)));
         end
      end
      send_queue(s);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed calendar corners
      send_text("29/02/2000");   // leap by the 400 rule
      send_text("29/2/1900");    // century, not leap
      send_text("29/2/2100");
      send_text("28/2/2100");
      send_text("31/12/2101");   // top of the year range
      send_text("1/1/1900");     // bottom of the year range
      send_text("31/12/1899");
      send_text("1/1/2102");
      send_text("31/4/2024");    // 30-day month
      send_text("30/4/99");      // short year lands in 2099
      send_text("29/2/00");
      send_text("0/1/2000");
      send_text("1/13/2000");
      send_text("12/05");        // NUL inside the month field
      send_text("7");            // NUL inside the day field
      send_text("");             // bare NUL
      send_text("123/1/2000");   // overlong day
      send_text("1/1/20000");    // overlong year
      send_text("-1/1/2000");    // negative day reads as zero
      send_text("1/1/-0");       // minus zero is year 2000
      send_text("1/1/-5");
      send_text("1/1/20/1");     // slash inside the year ends the number
      send_text(" 9/\t3/+099");  // blanks and signs count toward length
      send_text("1/1/200");      // three-character year
      send_char(dsv_pkg::CHAR_CR);  // other whitespace codes
      send_text("5/\n6/1984");
      send_char(8'hff);          // high bytes are non-digits
      send_char(8'h80);
      send_text("/1/2000");

      // random part in three idle regimes
      while (chars_sent < 650) send_random_string();
      tx_idle = 52;
      rx_idle = 35;
      while (chars_sent < 1250) send_random_string();
      tx_idle = 0;
      rx_idle = 0;
      while (chars_sent < 1850) send_random_string();

      // drain, then watch for anything stray
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.verdicts_due.size() != 0);
      repeat (8) @(posedge clock);

      $display("covered %0d date strings in %0d characters under three idle regimes",
               strings_sent, chars_sent);
      $display("%0d verdicts checked, %0d valid dates, %0d mismatches",
               sb.checked, sb.valid_seen, sb.errors);
      if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
         $display("PASS date_string_validator_core");
      end else begin
         $display("FAIL date_string_validator_core");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout with %0d verdicts still due", sb.verdicts_due.size());
      $display("FAIL date_string_validator_core");
      $finish;
   end

endmodule

@@ filelist.f @@
src/dsv_pkg.sv
src/dsv_parser.sv
src/dsv_check.sv
src/date_string_validator_core.sv
dv/tb_date_string_validator_core.sv
